// ===== hw/rtl/pcrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Pinhole camera ray direction: shared types and constants
// Register indexes, reset values and fixed field widths of the ray unit.
// ----------------------------------------------------------------------------
package pcrd_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_TAN_HALF     = 3'd2;
  localparam logic [2:0] CFG_FORWARD      = 3'd3;
  localparam logic [2:0] CFG_RIGHT        = 3'd4;
  localparam logic [2:0] CFG_UP           = 3'd5;

  // Reset values of the configuration registers
  localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [23:0] RST_TAN_HALF     = 24'd37837;

  // Fixed widths
  localparam int unsigned PIX_W     = 12;
  localparam int unsigned NRM_W     = 23;  // normalized magnitude, top bit at 2^22
  localparam int unsigned LEN_W     = 30;  // integer square root of the scaled sum
  localparam int unsigned RAD_W     = 60;  // radicand width
  localparam int unsigned SQ_STAGES = 30;  // one root bit per stage

  // Normalized vector with its sign and degenerate flag
  typedef struct packed {
    logic                        zero;
    logic [2:0]                  neg;
    logic [2:0][NRM_W-1:0]       mag;
  } norm_t;

endpackage

// ===== hw/rtl/pcrd_if.sv =====
// ----------------------------------------------------------------------------
// Pinhole camera ray direction: channel interfaces
// Pixel input channel and direction output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcrd_pix_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_column;
  logic [11:0] pixel_row;

  modport source (output valid, output pixel_column, output pixel_row, input ready);
  modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

interface pcrd_dir_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

// ===== hw/rtl/pinhole_camera_ray_direction_top.sv =====
// ----------------------------------------------------------------------------
// Pinhole camera primary ray direction
// Turns a pixel column/row into the unit direction of the ray through the
// pixel centre, Q1.DIR_FRAC_BITS per component.
// ----------------------------------------------------------------------------
// The unit takes one pixel beat per cycle and returns one direction beat per
// pixel, in order, as Q1.14 at the default. Eight stages form the exact
// scaled sum and normalize it, two stages square and add the lanes into the
// radicand, thirty stages of the square-root pipeline produce one root bit
// each, one stage builds the dividend, DIR_FRAC_BITS+2 divider stages produce
// one quotient bit each per component, and one output register closes the
// pipe. When a finished beat is not taken, the whole pipe holds and the input
// is not ready. Configuration writes take effect at once and are meant for an
// empty pipe.
module pinhole_camera_ray_direction_top #(
  parameter int PIXEL_BITS    = 12,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  pcrd_pix_if.sink    pix_i,
  pcrd_dir_if.source  dir_o
);

  localparam int QW       = DIR_FRAC_BITS + 2;   // quotient bits
  localparam int NW       = DIR_FRAC_BITS + 30;  // dividend bits
  localparam int NST      = 42 + QW;             // pipeline stages
  localparam int ST_ND    = 40;                  // dividend stage
  localparam int PixKeep  = (PIXEL_BITS < 12) ? PIXEL_BITS : 12;
  localparam logic [11:0] PixMask = 12'((64'd1 << PixKeep) - 64'd1);
  localparam logic [QW-1:0] QOne  = QW'(1) << DIR_FRAC_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [12:0] width_q, height_q;
  logic [23:0] tan_q;
  logic [47:0] fwd_q, rgt_q, up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pcrd_pkg::RST_IMAGE_WIDTH;
      height_q <= pcrd_pkg::RST_IMAGE_HEIGHT;
      tan_q    <= pcrd_pkg::RST_TAN_HALF;
      fwd_q    <= '0;
      rgt_q    <= '0;
      up_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcrd_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[12:0];
        pcrd_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[12:0];
        pcrd_pkg::CFG_TAN_HALF:     tan_q    <= cfg_data_i[23:0];
        pcrd_pkg::CFG_FORWARD:      fwd_q    <= cfg_data_i;
        pcrd_pkg::CFG_RIGHT:        rgt_q    <= cfg_data_i;
        pcrd_pkg::CFG_UP:           up_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance and valid chain
  // --------------------------------------------------------------------------
  logic           adv;
  logic [NST-1:0] vld_q;

  assign adv         = !vld_q[NST-1] || dir_o.ready;
  assign pix_i.ready = adv;
  assign dir_o.valid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], pix_i.valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: plane offsets 2i+1-W and 2j+1-H
  // --------------------------------------------------------------------------
  logic [11:0]        col_m, row_m;
  logic signed [14:0] ox_q, oy_q;

  assign col_m = pix_i.pixel_column & PixMask;
  assign row_m = pix_i.pixel_row & PixMask;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_q <= $signed({2'b00, col_m, 1'b1}) - $signed({2'b00, width_q});
      oy_q <= $signed({2'b00, row_m, 1'b1}) - $signed({2'b00, height_q});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale offsets by the tangent
  // --------------------------------------------------------------------------
  logic signed [39:0] ax_q, ay_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q <= ox_q * $signed({1'b0, tan_q});
      ay_q <= oy_q * $signed({1'b0, tan_q});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: per-lane products with the camera axes
  // --------------------------------------------------------------------------
  logic signed [29:0] fw;
  logic signed [15:0] lf [3];
  logic signed [15:0] lr [3];
  logic signed [15:0] lu [3];
  logic signed [55:0] pf_q [3];
  logic signed [55:0] pr_q [3];
  logic signed [55:0] pu_q [3];

  assign fw = $signed({1'b0, height_q, 16'h0000});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lf[k] = $signed(fwd_q[16*k +: 16]);
      lr[k] = $signed(rgt_q[16*k +: 16]);
      lu[k] = $signed(up_q[16*k +: 16]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pf_q[k] <= fw * lf[k];
        pr_q[k] <= ax_q * lr[k];
        pu_q[k] <= ay_q * lu[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: exact scaled direction
  // --------------------------------------------------------------------------
  logic signed [57:0] d_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= 58'(pf_q[k]) + 58'(pr_q[k]) + 58'(pu_q[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: split into sign and magnitude, collect the leading-one word
  // --------------------------------------------------------------------------
  logic [55:0] mag_d [3];
  logic [55:0] mag5_q [3];
  logic [2:0]  neg5_q;
  logic [55:0] or5_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_d[k] = d_q[k][57] ? 56'(-d_q[k]) : 56'(d_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        mag5_q[k] <= mag_d[k];
        neg5_q[k] <= d_q[k][57];
      end
      or5_q <= mag_d[0] | mag_d[1] | mag_d[2];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: leading one inside each byte
  // --------------------------------------------------------------------------
  logic [6:0]  cnz_d, cnz_q;
  logic [2:0]  cpos_d [7];
  logic [2:0]  cpos_q [7];
  logic [55:0] mag6_q [3];
  logic [2:0]  neg6_q;

  always_comb begin
    for (int c = 0; c < 7; c++) begin
      cnz_d[c]  = |or5_q[8*c +: 8];
      cpos_d[c] = '0;
      for (int b = 0; b < 8; b++) begin
        if (or5_q[8*c+b]) cpos_d[c] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cnz_q  <= cnz_d;
      cpos_q <= cpos_d;
      mag6_q <= mag5_q;
      neg6_q <= neg5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: pick the top byte, derive the shift that puts the lead at 2^22
  // --------------------------------------------------------------------------
  logic [5:0]  lead;
  logic        shr_d, shr_q, zero7_q;
  logic [5:0]  sh_d, sh_q;
  logic [55:0] mag7_q [3];
  logic [2:0]  neg7_q;

  always_comb begin
    lead = '0;
    for (int c = 0; c < 7; c++) begin
      if (cnz_q[c]) lead = {3'(c), cpos_q[c]};
    end
    shr_d = lead >= 6'd22;
    sh_d  = shr_d ? (lead - 6'd22) : (6'd22 - lead);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      shr_q   <= shr_d;
      sh_q    <= sh_d;
      zero7_q <= ~|cnz_q;
      mag7_q  <= mag6_q;
      neg7_q  <= neg6_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: normalize (right shift truncates)
  // --------------------------------------------------------------------------
  pcrd_pkg::norm_t n8_d, n8_q;

  always_comb begin
    n8_d.zero = zero7_q;
    n8_d.neg  = neg7_q;
    for (int k = 0; k < 3; k++) begin
      n8_d.mag[k] = shr_q ? pcrd_pkg::NRM_W'(mag7_q[k] >> sh_q)
                          : pcrd_pkg::NRM_W'(mag7_q[k] << sh_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) n8_q <= n8_d;
  end

  // --------------------------------------------------------------------------
  // Stages 9-10: sum of squares, scaled by 4096 into the radicand
  // --------------------------------------------------------------------------
  logic [45:0]                  sq_q [3];
  pcrd_pkg::norm_t              n9_q, n10_q;
  logic [47:0]                  ssum;
  logic [pcrd_pkg::RAD_W-1:0]   rad_q;

  assign ssum = 48'(sq_q[0]) + 48'(sq_q[1]) + 48'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= 46'(n8_q.mag[k]) * 46'(n8_q.mag[k]);
      end
      n9_q  <= n8_q;
      rad_q <= {ssum, 12'h000};
      n10_q <= n9_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square-root pipeline: one root bit per stage
  // --------------------------------------------------------------------------
  logic [33:0]                rem_sq_q  [pcrd_pkg::SQ_STAGES];
  logic [29:0]                root_sq_q [pcrd_pkg::SQ_STAGES];
  logic [pcrd_pkg::RAD_W-1:0] rad_sq_q  [pcrd_pkg::SQ_STAGES];
  pcrd_pkg::norm_t            nrm_sq_q  [pcrd_pkg::SQ_STAGES];

  for (genvar n = 0; n < pcrd_pkg::SQ_STAGES; n++) begin : g_sqrt
    logic [33:0]                rem_in, rem_sh, trial;
    logic [29:0]                root_in;
    logic [pcrd_pkg::RAD_W-1:0] rad_in;
    pcrd_pkg::norm_t            nrm_in;

    if (n == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_q;
      assign nrm_in  = n10_q;
    end else begin : g_next
      assign rem_in  = rem_sq_q[n-1];
      assign root_in = root_sq_q[n-1];
      assign rad_in  = rad_sq_q[n-1];
      assign nrm_in  = nrm_sq_q[n-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_in[31:0], rad_in[pcrd_pkg::RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rad_sq_q[n] <= {rad_in[pcrd_pkg::RAD_W-3:0], 2'b00};
        nrm_sq_q[n] <= nrm_in;
        if (rem_sh >= trial) begin
          rem_sq_q[n]  <= rem_sh - trial;
          root_sq_q[n] <= {root_in[28:0], 1'b1};
        end else begin
          rem_sq_q[n]  <= rem_sh;
          root_sq_q[n] <= {root_in[28:0], 1'b0};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Dividend: magnitude * 2^(DIR_FRAC_BITS+6) + len/2 for rounding
  // --------------------------------------------------------------------------
  logic [29:0]    len;
  logic [NW-1:0]  num_q [3];
  logic [29:0]    len_q;
  logic           nz_q;
  logic [2:0]     nneg_q;

  assign len = root_sq_q[pcrd_pkg::SQ_STAGES-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= (NW'(nrm_sq_q[pcrd_pkg::SQ_STAGES-1].mag[k]) << (DIR_FRAC_BITS + 6))
                    + NW'(len >> 1);
      end
      len_q  <= len;
      nz_q   <= nrm_sq_q[pcrd_pkg::SQ_STAGES-1].zero;
      nneg_q <= nrm_sq_q[pcrd_pkg::SQ_STAGES-1].neg;
    end
  end

  // --------------------------------------------------------------------------
  // Divider pipeline: one quotient bit per stage for each lane
  // --------------------------------------------------------------------------
  logic [NW-1:0] dnum_q [QW][3];
  logic [29:0]   drem_q [QW][3];
  logic [QW-1:0] dquo_q [QW][3];
  logic [29:0]   dlen_q [QW];
  logic          dz_q   [QW];
  logic [2:0]    dneg_q [QW];

  for (genvar m = 0; m < QW; m++) begin : g_div
    logic [29:0] len_in;

    if (m == 0) begin : g_first
      assign len_in = len_q;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dlen_q[m] <= len_q;
          dz_q[m]   <= nz_q;
          dneg_q[m] <= nneg_q;
        end
      end
    end else begin : g_next
      assign len_in = dlen_q[m-1];
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dlen_q[m] <= dlen_q[m-1];
          dz_q[m]   <= dz_q[m-1];
          dneg_q[m] <= dneg_q[m-1];
        end
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [NW-1:0] num_in;
      logic [29:0]   rem_in;
      logic [QW-1:0] quo_in;
      logic [30:0]   rem_sh;
      logic          ge;

      if (m == 0) begin : g_first
        assign num_in = num_q[k];
        assign rem_in = 30'(num_q[k] >> QW);
        assign quo_in = '0;
      end else begin : g_next
        assign num_in = dnum_q[m-1][k];
        assign rem_in = drem_q[m-1][k];
        assign quo_in = dquo_q[m-1][k];
      end

      // shift in the next dividend bit, subtract when it fits
      assign rem_sh = {rem_in, num_in[QW-1-m]};
      assign ge     = rem_sh >= {1'b0, len_in};

      always_ff @(posedge clk_i) begin
        if (adv) begin
          dnum_q[m][k] <= num_in;
          drem_q[m][k] <= ge ? 30'(rem_sh - {1'b0, len_in}) : 30'(rem_sh);
          dquo_q[m][k] <= {quo_in[QW-2:0], ge};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: clamp to one, apply sign, drop the degenerate case
  // --------------------------------------------------------------------------
  logic [QW-1:0] qc   [3];
  logic [32:0]   qs   [3];
  logic [15:0]   dir_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = (dquo_q[QW-1][k] > QOne) ? QOne : dquo_q[QW-1][k];
      qs[k] = dneg_q[QW-1][k] ? -33'(qc[k]) : 33'(qc[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dir_q[k] <= dz_q[QW-1] ? 16'h0000 : qs[k][15:0];
      end
    end
  end

  assign dir_o.dir_x = $signed(dir_q[0]);
  assign dir_o.dir_y = $signed(dir_q[1]);
  assign dir_o.dir_z = $signed(dir_q[2]);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [pcrd_pkg::NRM_W-1:0] n8_or;

  assign n8_or = n8_q.mag[0] | n8_q.mag[1] | n8_q.mag[2];

  // normalizer puts the largest magnitude in [2^22, 2^23)
  a_norm_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] && !n8_q.zero |-> n8_or[pcrd_pkg::NRM_W-1])
    else $error("normalized vector has no leading one at the top bit");

  // a non-degenerate vector yields a root of at least 2^28
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_ND] && !nz_q |-> len_q[29:28] != 2'b00)
    else $error("square root below expected range");

  // the divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_ND+QW] && !dz_q[QW-1] |->
      (drem_q[QW-1][0] < dlen_q[QW-1]) && (drem_q[QW-1][1] < dlen_q[QW-1]) &&
      (drem_q[QW-1][2] < dlen_q[QW-1]))
    else $error("divider remainder not below divisor");

endmodule

// ===== test/tb_pinhole_camera_ray_direction_top.sv =====
// ----------------------------------------------------------------------------
// Pinhole camera ray direction: self-checking testbench
// Drives pixel beats under a series of camera settings, with random gaps on
// the pixel side and random back-pressure on the direction side. A scoreboard
// works out each unit direction in exact integer arithmetic and compares it,
// in order, with every direction beat that the unit returns.
// ----------------------------------------------------------------------------
module tb_pinhole_camera_ray_direction_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned LONG_STALL   = 400;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } ray_dir_t;

  // --------------------------------------------------------------------------
  // Scoreboard: camera copy, direction predictor and queue of pending rays
  // --------------------------------------------------------------------------
  class ray_scoreboard;
    logic [12:0] img_w;
    logic [12:0] img_h;
    logic [23:0] tan_half;
    logic [47:0] fwd_axis;
    logic [47:0] right_axis;
    logic [47:0] up_axis;
    ray_dir_t    pending_rays[$];
    int unsigned mismatches;

    function new();
      img_w      = pcrd_pkg::RST_IMAGE_WIDTH;
      img_h      = pcrd_pkg::RST_IMAGE_HEIGHT;
      tan_half   = pcrd_pkg::RST_TAN_HALF;
      fwd_axis   = '0;
      right_axis = '0;
      up_axis    = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [47:0] val);
      case (idx)
        pcrd_pkg::CFG_IMAGE_WIDTH:  img_w      = val[12:0];
        pcrd_pkg::CFG_IMAGE_HEIGHT: img_h      = val[12:0];
        pcrd_pkg::CFG_TAN_HALF:     tan_half   = val[23:0];
        pcrd_pkg::CFG_FORWARD:      fwd_axis   = val;
        pcrd_pkg::CFG_RIGHT:        right_axis = val;
        pcrd_pkg::CFG_UP:           up_axis    = val;
        default: ;
      endcase
    endfunction

    function longint axis_lane(logic [47:0] packed_v, int k);
      logic signed [15:0] s;
      s = packed_v[16*k +: 16];
      return longint'(s);
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= root + bitv) begin
          x    = x - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    // Exact scaled sum, normalize, then divide by the root length
    function ray_dir_t predict_dir(logic [11:0] col, logic [11:0] row);
      longint          ci, rj, w, h, t, ax, ay, fw, d;
      longint unsigned mag[3];
      bit              neg[3];
      longint unsigned maxm, sq, len, q;
      logic [15:0]     comp[3];
      ray_dir_t        r;
      ci = longint'(col);
      rj = longint'(row);
      w  = longint'(img_w);
      h  = longint'(img_h);
      t  = longint'(tan_half);
      ax = (2 * ci + 1 - w) * t;
      ay = (2 * rj + 1 - h) * t;
      fw = h * 65536;
      maxm = 0;
      for (int k = 0; k < 3; k++) begin
        d = fw * axis_lane(fwd_axis, k) + ax * axis_lane(right_axis, k)
          + ay * axis_lane(up_axis, k);
        neg[k] = d < 0;
        mag[k] = neg[k] ? longint'(-d) : longint'(d);
        if (mag[k] > maxm) maxm = mag[k];
      end
      if (maxm == 0) return '0;
      while (maxm >= (64'd1 << 23)) begin
        maxm = maxm >> 1;
        for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
      end
      while (maxm < (64'd1 << 22)) begin
        maxm = maxm << 1;
        for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
      end
      sq  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = int_sqrt(sq << 12);
      for (int k = 0; k < 3; k++) begin
        q = ((mag[k] << 20) + len / 2) / len;
        if (q > 64'd16384) q = 64'd16384;
        if (neg[k]) q = -q;
        comp[k] = q[15:0];
      end
      r.x = comp[0];
      r.y = comp[1];
      r.z = comp[2];
      return r;
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row);
      pending_rays.push_back(predict_dir(col, row));
    endfunction

    function void check_dir(ray_dir_t got);
      ray_dir_t exp_dir;
      if (pending_rays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected direction beat x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        return;
      end
      exp_dir = pending_rays.pop_front();
      if (got !== exp_dir) begin
        mismatches++;
        if (mismatches <= 10)
          $display("direction mismatch: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                   exp_dir.x, exp_dir.y, exp_dir.z, got.x, got.y, got.z);
      end
    endfunction

    function bit busy();
      return pending_rays.size() != 0;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = pcrd_pkg::CFG_IMAGE_WIDTH;
  logic [47:0] cfg_data_i = '0;
  bit          stall_req = 1'b0;
  int unsigned cycle_cnt = 0;

  pcrd_pix_if pix ();
  pcrd_dir_if dirc ();

  ray_scoreboard sb = new();

  pinhole_camera_ray_direction_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .dir_o      (dirc)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check each direction beat; values are stable at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && dirc.valid && dirc.ready)
      sb.check_dir('{x: dirc.dir_x, y: dirc.dir_y, z: dirc.dir_z});
  end

  // Receiver: random ready stretches, plus one long hold-off on request
  initial begin
    int unsigned hold;
    bit          rdy;
    hold = 0;
    rdy  = 1'b0;
    dirc.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        dirc.ready <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk_i);
        stall_req = 1'b0;
        hold = 0;
      end else begin
        if (hold == 0) begin
          if ($urandom_range(0, 99) < 65) begin
            rdy  = 1'b1;
            hold = $urandom_range(1, 30);
          end else begin
            rdy  = 1'b0;
            hold = ($urandom_range(0, 99) < 5) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 4);
          end
        end
        hold--;
        dirc.ready <= rdy;
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 97) return $urandom_range(1, 3);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [47:0] pack_axis(int x, int y, int z);
    logic [15:0] a, b, c;
    a = x[15:0];
    b = y[15:0];
    c = z[15:0];
    return {c, b, a};
  endfunction

  function automatic logic [47:0] rand_axis();
    if ($urandom_range(0, 99) < 75)
      return pack_axis($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                       $urandom_range(0, 32768) - 16384);
    return 48'({$urandom(), $urandom()});
  endfunction

  // Offer one pixel beat and hold it until it is taken
  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    int unsigned g;
    bit          taken;
    g = gap_len();
    if (g > 0) begin
      pix.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    pix.valid        <= 1'b1;
    pix.pixel_column <= col;
    pix.pixel_row    <= row;
    do begin
      @(negedge clk_i);
      taken = pix.ready;
      @(posedge clk_i);
    end while (!taken);
    sb.note_pixel(col, row);
  endtask

  // Drop valid and let every pending ray drain out
  task automatic drain_pipe();
    pix.valid <= 1'b0;
    while (sb.busy()) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Load a full camera setting into an idle pipe
  task automatic set_camera(logic [12:0] w, logic [12:0] h, logic [23:0] t,
                            logic [47:0] f, logic [47:0] r, logic [47:0] u);
    drain_pipe();
    write_reg(pcrd_pkg::CFG_IMAGE_WIDTH, 48'(w));
    write_reg(pcrd_pkg::CFG_IMAGE_HEIGHT, 48'(h));
    write_reg(pcrd_pkg::CFG_TAN_HALF, 48'(t));
    write_reg(pcrd_pkg::CFG_FORWARD, f);
    write_reg(pcrd_pkg::CFG_RIGHT, r);
    write_reg(pcrd_pkg::CFG_UP, u);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [12:0] w, h;
    logic [23:0] t;
    logic [11:0] col, row;
    pix.valid        = 1'b0;
    pix.pixel_column = '0;
    pix.pixel_row    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: all axes zero, so the sum is zero
    send_pixel(12'd0, 12'd0);

    // Standard basis with odd size: center pixel hits the forward axis
    set_camera(13'd641, 13'd481, 24'd37837, pack_axis(0, 0, 16384),
               pack_axis(16384, 0, 0), pack_axis(0, -16384, 0));
    send_pixel(12'd320, 12'd240);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd640, 12'd480);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);

    // One-pixel image with zero tangent and zero forward axis
    set_camera(13'd1, 13'd1, 24'd0, '0, pack_axis(16384, 0, 0), pack_axis(0, 16384, 0));
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd5, 12'd7);

    // Largest image and tangent, most negative and most positive lanes
    set_camera(13'd4096, 13'd4096, 24'hFFFFFF, {3{16'h8000}}, {3{16'h7FFF}},
               {3{16'h8000}});
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd2048, 12'd2048);

    // Zero height: the forward term vanishes
    set_camera(13'd640, 13'd0, 24'd37837, pack_axis(0, 0, 16384),
               pack_axis(16384, 0, 0), pack_axis(0, 16384, 0));
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd639, 12'd10);

    // All register bits set
    set_camera(13'h1FFF, 13'h1FFF, 24'hFFFFFF, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
    send_pixel(12'd1234, 12'd2345);
    send_pixel(12'hAAA, 12'h555);

    // Random camera settings, pixels mostly inside the image
    for (int phase = 0; phase < 10; phase++) begin
      w = ($urandom_range(0, 9) == 0) ? 13'($urandom()) : 13'($urandom_range(1, 4096));
      h = ($urandom_range(0, 9) == 0) ? 13'($urandom()) : 13'($urandom_range(1, 4096));
      t = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(8000, 120000));
      set_camera(w, h, t, rand_axis(), rand_axis(), rand_axis());
      for (int n = 0; n < 125; n++) begin
        if (phase == 3 && n == 20) stall_req = 1'b1;
        if ($urandom_range(0, 99) < 80 && w != 0 && h != 0) begin
          col = 12'($urandom_range(0, int'(w) - 1));
          row = 12'($urandom_range(0, int'(h) - 1));
        end else begin
          col = 12'($urandom());
          row = 12'($urandom());
        end
        send_pixel(col, row);
      end
    end

    drain_pipe();
    if (sb.mismatches == 0 && !sb.busy()) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
